// ===== rtl/cclk_pkg.sv =====
// cclk_pkg: command codes, reset values and month-length lookup for the
// calendar clock counter. No dependencies.

package cclk_pkg;

    // Command codes carried in the cmd field of an input item
    typedef enum logic [1:0] {
        CMD_TICK     = 2'd0,
        CMD_SET_TIME = 2'd1,
        CMD_SET_DATE = 2'd2,
        CMD_NONE     = 2'd3
    } t_cmd;

    // Field widths
    localparam int unsigned SEC_W   = 6;
    localparam int unsigned MIN_W   = 6;
    localparam int unsigned HOUR_W  = 5;
    localparam int unsigned DAY_W   = 5;
    localparam int unsigned MONTH_W = 4;
    localparam int unsigned YEAR_W  = 14;

    // Limits
    localparam logic [SEC_W:0]   SEC_MAX   = 7'd59;
    localparam logic [MIN_W:0]   MIN_MAX   = 7'd59;
    localparam logic [HOUR_W:0]  HOUR_MAX  = 6'd23;
    localparam logic [MONTH_W:0] MONTH_MAX = 5'd12;
    localparam logic [YEAR_W:0]  YEAR_MAX  = 15'd9999;

    // Values after reset
    localparam logic [SEC_W-1:0]   RST_SEC   = 6'd0;
    localparam logic [MIN_W-1:0]   RST_MIN   = 6'd30;
    localparam logic [HOUR_W-1:0]  RST_HOUR  = 5'd8;
    localparam logic [DAY_W-1:0]   RST_DAY   = 5'd10;
    localparam logic [MONTH_W-1:0] RST_MONTH = 4'd4;
    localparam logic [YEAR_W-1:0]  RST_YEAR  = 14'd2022;

    // Days in a month; leap year is any year divisible by 4.
    // Month codes outside 1..12 get 31 days.
    function automatic logic [DAY_W-1:0] month_length(
        input logic [MONTH_W-1:0] month,
        input logic [YEAR_W-1:0]  year
    );
        logic [DAY_W-1:0] len;
        case (month) inside
            4'd2: begin
                len = (year[1:0] == 2'b00) ? 5'd29 : 5'd28;
            end
            4'd4, 4'd6, 4'd9, 4'd11: begin
                len = 5'd30;
            end
            default: begin
                len = 5'd31;
            end
        endcase
        return len;
    endfunction

endpackage

// ===== rtl/calendar_clock_counter_unit.sv =====
// calendar_clock_counter_unit: real-time calendar counter with tick and
// time/date write commands. Depends on cclk_pkg.
//
//   channel | direction | handshake           | payload
//   --------+-----------+---------------------+--------------------------------
//   in      | input     | i_valid / o_stall   | i_cmd, i_new_hour .. i_new_year
//   out     | output    | o_valid / i_stall   | o_cur_second .. o_cur_year
//
// Each item passes an input register, then one pass of carry logic that
// loads the calendar registers, which are also the output register.
// One item per cycle is sustained while the output is not stalled, the calendar
// registers being read and written in the same cycle of the carry logic.
// Reset (synchronous, active low) sets 08:30:00 on 10 April 2022.
// A stall at the output holds the calendar registers; the input register
// then fills and o_stall rises.

module calendar_clock_counter_unit (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // input channel
    input  logic                          i_valid,
    output logic                          o_stall,
    input  logic [1:0]                    i_cmd,
    input  logic [cclk_pkg::HOUR_W-1:0]   i_new_hour,
    input  logic [cclk_pkg::MIN_W-1:0]    i_new_minute,
    input  logic [cclk_pkg::SEC_W-1:0]    i_new_second,
    input  logic [cclk_pkg::DAY_W-1:0]    i_new_day,
    input  logic [cclk_pkg::MONTH_W-1:0]  i_new_month,
    input  logic [cclk_pkg::YEAR_W-1:0]   i_new_year,
    // output channel
    output logic                          o_valid,
    input  logic                          i_stall,
    output logic [cclk_pkg::SEC_W-1:0]    o_cur_second,
    output logic [cclk_pkg::MIN_W-1:0]    o_cur_minute,
    output logic [cclk_pkg::HOUR_W-1:0]   o_cur_hour,
    output logic [cclk_pkg::DAY_W-1:0]    o_cur_day,
    output logic [cclk_pkg::MONTH_W-1:0]  o_cur_month,
    output logic [cclk_pkg::YEAR_W-1:0]   o_cur_year
);

    // Input register
    logic                          r_in_valid;
    cclk_pkg::t_cmd                r_cmd;
    logic [cclk_pkg::HOUR_W-1:0]   r_new_hour;
    logic [cclk_pkg::MIN_W-1:0]    r_new_minute;
    logic [cclk_pkg::SEC_W-1:0]    r_new_second;
    logic [cclk_pkg::DAY_W-1:0]    r_new_day;
    logic [cclk_pkg::MONTH_W-1:0]  r_new_month;
    logic [cclk_pkg::YEAR_W-1:0]   r_new_year;

    // Calendar registers (also the output register)
    logic                          r_out_valid;
    logic [cclk_pkg::SEC_W-1:0]    r_sec;
    logic [cclk_pkg::MIN_W-1:0]    r_min;
    logic [cclk_pkg::HOUR_W-1:0]   r_hour;
    logic [cclk_pkg::DAY_W-1:0]    r_day;
    logic [cclk_pkg::MONTH_W-1:0]  r_month;
    logic [cclk_pkg::YEAR_W-1:0]   r_year;

    logic [cclk_pkg::SEC_W-1:0]    n_sec;
    logic [cclk_pkg::MIN_W-1:0]    n_min;
    logic [cclk_pkg::HOUR_W-1:0]   n_hour;
    logic [cclk_pkg::DAY_W-1:0]    n_day;
    logic [cclk_pkg::MONTH_W-1:0]  n_month;
    logic [cclk_pkg::YEAR_W-1:0]   n_year;

    // Handshake control
    logic out_free;
    logic advance;
    logic in_load;

    assign out_free = !r_out_valid || !i_stall;
    assign advance  = r_in_valid && out_free;
    assign in_load  = i_valid && !o_stall;
    assign o_stall  = r_in_valid && !out_free;
    assign o_valid  = r_out_valid;

    // Capture an accepted item
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_load) begin
            r_in_valid <= 1'b1;
        end else if (advance) begin
            r_in_valid <= 1'b0;
        end
        if (in_load) begin
            r_cmd        <= cclk_pkg::t_cmd'(i_cmd);
            r_new_hour   <= i_new_hour;
            r_new_minute <= i_new_minute;
            r_new_second <= i_new_second;
            r_new_day    <= i_new_day;
            r_new_month  <= i_new_month;
            r_new_year   <= i_new_year;
        end
    end

    // Tick carry chain; each stage compared whether or not a carry came in
    logic [cclk_pkg::SEC_W:0]      sec_p;
    logic [cclk_pkg::MIN_W:0]      min_p;
    logic [cclk_pkg::HOUR_W:0]     hour_p;
    logic [cclk_pkg::DAY_W:0]      day_p;
    logic [cclk_pkg::MONTH_W:0]    month_p;
    logic [cclk_pkg::YEAR_W:0]     year_p;
    logic                          c_sec;
    logic                          c_min;
    logic                          c_hour;
    logic                          c_day;
    logic                          c_month;
    logic [cclk_pkg::DAY_W-1:0]    mlen;
    logic [cclk_pkg::SEC_W-1:0]    t_sec;
    logic [cclk_pkg::MIN_W-1:0]    t_min;
    logic [cclk_pkg::HOUR_W-1:0]   t_hour;
    logic [cclk_pkg::DAY_W-1:0]    t_day;
    logic [cclk_pkg::MONTH_W-1:0]  t_month;
    logic [cclk_pkg::YEAR_W-1:0]   t_year;

    always_comb begin
        sec_p  = {1'b0, r_sec} + 7'd1;
        c_sec  = sec_p > cclk_pkg::SEC_MAX;
        t_sec  = c_sec ? '0 : sec_p[cclk_pkg::SEC_W-1:0];

        min_p  = {1'b0, r_min} + {6'd0, c_sec};
        c_min  = min_p > cclk_pkg::MIN_MAX;
        t_min  = c_min ? '0 : min_p[cclk_pkg::MIN_W-1:0];

        hour_p = {1'b0, r_hour} + {5'd0, c_min};
        c_hour = hour_p > cclk_pkg::HOUR_MAX;
        t_hour = c_hour ? '0 : hour_p[cclk_pkg::HOUR_W-1:0];

        mlen   = cclk_pkg::month_length(r_month, r_year);
        day_p  = {1'b0, r_day} + {5'd0, c_hour};
        c_day  = day_p > {1'b0, mlen};
        t_day  = c_day ? 5'd1 : day_p[cclk_pkg::DAY_W-1:0];

        month_p = {1'b0, r_month} + {4'd0, c_day};
        c_month = month_p > cclk_pkg::MONTH_MAX;
        t_month = c_month ? 4'd1 : month_p[cclk_pkg::MONTH_W-1:0];

        // year moves only on a month carry and wraps past 9999
        year_p = {1'b0, r_year} + 15'd1;
        if (!c_month) begin
            t_year = r_year;
        end else if (year_p > cclk_pkg::YEAR_MAX) begin
            t_year = '0;
        end else begin
            t_year = year_p[cclk_pkg::YEAR_W-1:0];
        end
    end

    // Command select
    always_comb begin
        n_sec   = r_sec;
        n_min   = r_min;
        n_hour  = r_hour;
        n_day   = r_day;
        n_month = r_month;
        n_year  = r_year;
        case (r_cmd)
            cclk_pkg::CMD_TICK: begin
                n_sec   = t_sec;
                n_min   = t_min;
                n_hour  = t_hour;
                n_day   = t_day;
                n_month = t_month;
                n_year  = t_year;
            end
            cclk_pkg::CMD_SET_TIME: begin
                n_hour = r_new_hour;
                n_min  = r_new_minute;
                n_sec  = r_new_second;
            end
            cclk_pkg::CMD_SET_DATE: begin
                n_day   = r_new_day;
                n_month = r_new_month;
                n_year  = r_new_year;
            end
            default: begin
                // unused command leaves the calendar as it is
            end
        endcase
    end

    // Calendar registers and output valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_sec       <= cclk_pkg::RST_SEC;
            r_min       <= cclk_pkg::RST_MIN;
            r_hour      <= cclk_pkg::RST_HOUR;
            r_day       <= cclk_pkg::RST_DAY;
            r_month     <= cclk_pkg::RST_MONTH;
            r_year      <= cclk_pkg::RST_YEAR;
        end else begin
            if (advance) begin
                r_out_valid <= 1'b1;
                r_sec       <= n_sec;
                r_min       <= n_min;
                r_hour      <= n_hour;
                r_day       <= n_day;
                r_month     <= n_month;
                r_year      <= n_year;
            end else if (out_free) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_cur_second = r_sec;
    assign o_cur_minute = r_min;
    assign o_cur_hour   = r_hour;
    assign o_cur_day    = r_day;
    assign o_cur_month  = r_month;
    assign o_cur_year   = r_year;

    // Input side stalls only behind a full, stalled output register
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> (r_in_valid && r_out_valid && i_stall))
        else $error("input stalled without a blocked result");

    // Calendar moves only when an item passes into the output register
    a_hold_calendar: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !advance |=> ($stable(r_sec) && $stable(r_min) && $stable(r_hour)
                      && $stable(r_day) && $stable(r_month) && $stable(r_year)))
        else $error("calendar changed with no item");

    // Time write stores the given fields
    a_time_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (advance && r_cmd == cclk_pkg::CMD_SET_TIME) |=>
            (r_sec == $past(r_new_second) && r_min == $past(r_new_minute)
             && r_hour == $past(r_new_hour)))
        else $error("time write not stored");

    // Tick below the second limit only advances the second
    a_tick_plain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (advance && r_cmd == cclk_pkg::CMD_TICK && r_sec < 6'd59 && r_min < 6'd60
         && r_hour < 5'd24) |=>
            (r_sec == $past(r_sec) + 6'd1 && r_min == $past(r_min)
             && r_hour == $past(r_hour)))
        else $error("tick carried without overflow");

endmodule

// ===== sim/calendar_clock_counter_checker.sv =====
// calendar_clock_counter_checker: watches both channels of the calendar clock
// counter, predicts each result and compares it field by field.
// Depends on cclk_pkg.

module calendar_clock_counter_checker (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // input channel
    input  logic                                i_in_valid,
    input  logic                                i_in_stall,
    input  logic [1:0]                          i_cmd,
    input  logic [cclk_pkg::HOUR_W-1:0]         i_new_hour,
    input  logic [cclk_pkg::MIN_W-1:0]          i_new_minute,
    input  logic [cclk_pkg::SEC_W-1:0]          i_new_second,
    input  logic [cclk_pkg::DAY_W-1:0]          i_new_day,
    input  logic [cclk_pkg::MONTH_W-1:0]        i_new_month,
    input  logic [cclk_pkg::YEAR_W-1:0]         i_new_year,
    // output channel
    input  logic                                i_out_valid,
    input  logic                                i_out_stall,
    input  logic [cclk_pkg::SEC_W-1:0]          i_cur_second,
    input  logic [cclk_pkg::MIN_W-1:0]          i_cur_minute,
    input  logic [cclk_pkg::HOUR_W-1:0]         i_cur_hour,
    input  logic [cclk_pkg::DAY_W-1:0]          i_cur_day,
    input  logic [cclk_pkg::MONTH_W-1:0]        i_cur_month,
    input  logic [cclk_pkg::YEAR_W-1:0]         i_cur_year,
    // status for the testbench top
    output int                                  o_fail_count,
    output int                                  o_pending,
    output int                                  o_checked,
    output int                                  o_year_rolls,
    output int                                  o_year_wraps,
    output int                                  o_leap_days
);

    typedef struct packed {
        logic [cclk_pkg::SEC_W-1:0]   sec;
        logic [cclk_pkg::MIN_W-1:0]   minute;
        logic [cclk_pkg::HOUR_W-1:0]  hour;
        logic [cclk_pkg::DAY_W-1:0]   day;
        logic [cclk_pkg::MONTH_W-1:0] month;
        logic [cclk_pkg::YEAR_W-1:0]  year;
    } t_cal_time;

    t_cal_time cal_now;
    t_cal_time readings_due[$];

    // Days in a month; any year divisible by 4 is a leap year, other month codes get 31
    function automatic int unsigned days_in_month(input int unsigned mon,
                                                  input int unsigned yr);
        int unsigned len;
        len = 31;
        if (mon == 2) begin
            len = ((yr % 4) == 0) ? 29 : 28;
        end else if (mon == 4 || mon == 6 || mon == 9 || mon == 11) begin
            len = 30;
        end
        return len;
    endfunction

    // Calendar after one command; every stage is compared on a tick, carry or not
    function automatic t_cal_time calendar_after(
        input  t_cal_time                          c,
        input  logic [1:0]                         cmd,
        input  logic [cclk_pkg::HOUR_W-1:0]        hr,
        input  logic [cclk_pkg::MIN_W-1:0]         mn,
        input  logic [cclk_pkg::SEC_W-1:0]         sc,
        input  logic [cclk_pkg::DAY_W-1:0]         dy,
        input  logic [cclk_pkg::MONTH_W-1:0]       mo,
        input  logic [cclk_pkg::YEAR_W-1:0]        yr,
        output logic                               year_roll,
        output logic                               year_wrap
    );
        int unsigned s, m, h, d, mth, y;
        t_cal_time r;
        r = c;
        year_roll = 1'b0;
        year_wrap = 1'b0;
        case (cclk_pkg::t_cmd'(cmd))
            cclk_pkg::CMD_TICK: begin
                s   = c.sec + 1;
                m   = c.minute;
                h   = c.hour;
                d   = c.day;
                mth = c.month;
                y   = c.year;
                if (s > cclk_pkg::SEC_MAX) begin
                    s = 0;
                    m++;
                end
                if (m > cclk_pkg::MIN_MAX) begin
                    m = 0;
                    h++;
                end
                if (h > cclk_pkg::HOUR_MAX) begin
                    h = 0;
                    d++;
                end
                if (d > days_in_month(mth, y)) begin
                    d = 1;
                    mth++;
                end
                if (mth > cclk_pkg::MONTH_MAX) begin
                    mth = 1;
                    y++;
                    year_roll = 1'b1;
                    if (y > cclk_pkg::YEAR_MAX) begin
                        y = 0;
                        year_wrap = 1'b1;
                    end
                end
                r.sec    = s[cclk_pkg::SEC_W-1:0];
                r.minute = m[cclk_pkg::MIN_W-1:0];
                r.hour   = h[cclk_pkg::HOUR_W-1:0];
                r.day    = d[cclk_pkg::DAY_W-1:0];
                r.month  = mth[cclk_pkg::MONTH_W-1:0];
                r.year   = y[cclk_pkg::YEAR_W-1:0];
            end
            cclk_pkg::CMD_SET_TIME: begin
                r.hour   = hr;
                r.minute = mn;
                r.sec    = sc;
            end
            cclk_pkg::CMD_SET_DATE: begin
                r.day   = dy;
                r.month = mo;
                r.year  = yr;
            end
            default: begin
                // unused command leaves the calendar alone
            end
        endcase
        return r;
    endfunction

    task automatic check_field(input string what, input int unsigned want,
                               input int unsigned got);
        if (want != got) begin
            $display("%0t: %s mismatch: expected %0d, got %0d", $time, what, want, got);
            o_fail_count++;
        end
    endtask

    // Compare accepted results first, then predict the item accepted at this edge
    always @(posedge i_clk) begin : watch
        t_cal_time got, want, nxt;
        logic      roll, wrap;
        if (!i_rst_n) begin
            cal_now = '{sec: cclk_pkg::RST_SEC, minute: cclk_pkg::RST_MIN,
                        hour: cclk_pkg::RST_HOUR, day: cclk_pkg::RST_DAY,
                        month: cclk_pkg::RST_MONTH, year: cclk_pkg::RST_YEAR};
            readings_due.delete();
        end else begin
            if (i_out_valid && !i_out_stall) begin
                got = '{sec: i_cur_second, minute: i_cur_minute, hour: i_cur_hour,
                        day: i_cur_day, month: i_cur_month, year: i_cur_year};
                if (readings_due.size() == 0) begin
                    $display("%0t: result with nothing expected: %0d:%0d:%0d %0d/%0d/%0d",
                             $time, got.hour, got.minute, got.sec,
                             got.day, got.month, got.year);
                    o_fail_count++;
                end else begin
                    want = readings_due.pop_front();
                    check_field("second", want.sec, got.sec);
                    check_field("minute", want.minute, got.minute);
                    check_field("hour", want.hour, got.hour);
                    check_field("day", want.day, got.day);
                    check_field("month", want.month, got.month);
                    check_field("year", want.year, got.year);
                    o_checked++;
                end
            end
            if (i_in_valid && !i_in_stall) begin
                nxt = calendar_after(cal_now, i_cmd, i_new_hour, i_new_minute, i_new_second,
                                     i_new_day, i_new_month, i_new_year, roll, wrap);
                // a tick that lands on Feb 29
                if (cclk_pkg::t_cmd'(i_cmd) == cclk_pkg::CMD_TICK && nxt.month == 2
                        && nxt.day == 29 && cal_now.day == 28) begin
                    o_leap_days++;
                end
                if (roll) o_year_rolls++;
                if (wrap) o_year_wraps++;
                readings_due.push_back(nxt);
                cal_now = nxt;
            end
        end
        o_pending = readings_due.size();
    end

endmodule

// ===== sim/tb.sv =====
// tb: top of the calendar clock counter regression. Drives directed and random
// commands with random idling on both channels; checking is done by
// calendar_clock_counter_checker. Depends on cclk_pkg and the block.

module tb;

    localparam int unsigned QUIET_LIMIT = 1000;
    localparam int unsigned PHASES      = 6;
    localparam int unsigned PHASE_ITEMS = 317;

    logic                                i_clk = 1'b0;
    logic                                i_rst_n;
    logic                                i_valid;
    logic                                o_stall;
    logic [1:0]                          i_cmd;
    logic [cclk_pkg::HOUR_W-1:0]         i_new_hour;
    logic [cclk_pkg::MIN_W-1:0]          i_new_minute;
    logic [cclk_pkg::SEC_W-1:0]          i_new_second;
    logic [cclk_pkg::DAY_W-1:0]          i_new_day;
    logic [cclk_pkg::MONTH_W-1:0]        i_new_month;
    logic [cclk_pkg::YEAR_W-1:0]         i_new_year;
    logic                                o_valid;
    logic                                i_stall = 1'b0;
    logic [cclk_pkg::SEC_W-1:0]          o_cur_second;
    logic [cclk_pkg::MIN_W-1:0]          o_cur_minute;
    logic [cclk_pkg::HOUR_W-1:0]         o_cur_hour;
    logic [cclk_pkg::DAY_W-1:0]          o_cur_day;
    logic [cclk_pkg::MONTH_W-1:0]        o_cur_month;
    logic [cclk_pkg::YEAR_W-1:0]         o_cur_year;

    int          fail_count, pending, checked, year_rolls, year_wraps, leap_days;
    int unsigned tx_idle_max = 0;
    int unsigned rx_idle_max = 0;
    int unsigned rx_wait = 0;
    logic        rx_took = 1'b0;
    int unsigned quiet_cycles = 0;

    always #5 i_clk = ~i_clk;

    calendar_clock_counter_unit DUT (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_stall      (o_stall),
        .i_cmd        (i_cmd),
        .i_new_hour   (i_new_hour),
        .i_new_minute (i_new_minute),
        .i_new_second (i_new_second),
        .i_new_day    (i_new_day),
        .i_new_month  (i_new_month),
        .i_new_year   (i_new_year),
        .o_valid      (o_valid),
        .i_stall      (i_stall),
        .o_cur_second (o_cur_second),
        .o_cur_minute (o_cur_minute),
        .o_cur_hour   (o_cur_hour),
        .o_cur_day    (o_cur_day),
        .o_cur_month  (o_cur_month),
        .o_cur_year   (o_cur_year)
    );

    calendar_clock_counter_checker checker_i (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_valid),
        .i_in_stall   (o_stall),
        .i_cmd        (i_cmd),
        .i_new_hour   (i_new_hour),
        .i_new_minute (i_new_minute),
        .i_new_second (i_new_second),
        .i_new_day    (i_new_day),
        .i_new_month  (i_new_month),
        .i_new_year   (i_new_year),
        .i_out_valid  (o_valid),
        .i_out_stall  (i_stall),
        .i_cur_second (o_cur_second),
        .i_cur_minute (o_cur_minute),
        .i_cur_hour   (o_cur_hour),
        .i_cur_day    (o_cur_day),
        .i_cur_month  (o_cur_month),
        .i_cur_year   (o_cur_year),
        .o_fail_count (fail_count),
        .o_pending    (pending),
        .o_checked    (checked),
        .o_year_rolls (year_rolls),
        .o_year_wraps (year_wraps),
        .o_leap_days  (leap_days)
    );

    // Receiver: after each accepted result, stall for a random count of cycles
    always @(posedge i_clk) rx_took <= o_valid && !i_stall;

    always @(negedge i_clk) begin : receiver
        int unsigned w;
        w = rx_wait;
        if (rx_took) w = $urandom_range(rx_idle_max, 0);
        if (w != 0) begin
            i_stall <= 1'b1;
            rx_wait <= w - 1;
        end else begin
            i_stall <= 1'b0;
            rx_wait <= 0;
        end
    end

    // Watchdog: too long without any item moving on either channel
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_valid && !o_stall) || (o_valid && !i_stall)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles == QUIET_LIMIT) begin
            $display("%0t: no handshake for %0d cycles", $time, QUIET_LIMIT);
            $display("calendar_clock_counter_unit regression: fail");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // One item: random gap, then hold it until accepted
    task automatic push_item(
        input cclk_pkg::t_cmd                  c,
        input logic [cclk_pkg::HOUR_W-1:0]     hr,
        input logic [cclk_pkg::MIN_W-1:0]      mn,
        input logic [cclk_pkg::SEC_W-1:0]      sc,
        input logic [cclk_pkg::DAY_W-1:0]      dy,
        input logic [cclk_pkg::MONTH_W-1:0]    mo,
        input logic [cclk_pkg::YEAR_W-1:0]     yr
    );
        int unsigned gap;
        gap = $urandom_range(tx_idle_max, 0);
        @(negedge i_clk);
        if (gap != 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_cmd        <= c;
        i_new_hour   <= hr;
        i_new_minute <= mn;
        i_new_second <= sc;
        i_new_day    <= dy;
        i_new_month  <= mo;
        i_new_year   <= yr;
        i_valid      <= 1'b1;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
    endtask

    // Fields that the command ignores carry random bits
    task automatic send_bare(input cclk_pkg::t_cmd c);
        push_item(c, 5'($urandom_range(31, 0)), 6'($urandom_range(63, 0)),
                  6'($urandom_range(63, 0)), 5'($urandom_range(31, 0)),
                  4'($urandom_range(15, 0)), 14'($urandom_range(16383, 0)));
    endtask

    task automatic send_time(input int unsigned hr, input int unsigned mn, input int unsigned sc);
        push_item(cclk_pkg::CMD_SET_TIME, 5'(hr), 6'(mn), 6'(sc),
                  5'($urandom_range(31, 0)), 4'($urandom_range(15, 0)),
                  14'($urandom_range(16383, 0)));
    endtask

    task automatic send_date(input int unsigned dy, input int unsigned mo, input int unsigned yr);
        push_item(cclk_pkg::CMD_SET_DATE, 5'($urandom_range(31, 0)),
                  6'($urandom_range(63, 0)), 6'($urandom_range(63, 0)),
                  5'(dy), 4'(mo), 14'(yr));
    endtask

    // Stop sending and wait until every result is back
    task automatic drain();
        @(negedge i_clk);
        i_valid <= 1'b0;
        while (pending != 0) @(negedge i_clk);
    endtask

    // Mostly ticks after writes placed just before a rollover; some noise
    task automatic send_random_item();
        int unsigned r;
        r = $urandom_range(99, 0);
        if (r < 14) begin
            if ($urandom_range(9, 0) == 0) begin
                send_time($urandom_range(31, 0), $urandom_range(63, 0), $urandom_range(63, 0));
            end else begin
                send_time($urandom_range(1, 0) ? 23 : $urandom_range(23, 0),
                          $urandom_range(1, 0) ? 59 : $urandom_range(59, 0),
                          $urandom_range(59, 50));
            end
        end else if (r < 28) begin
            if ($urandom_range(9, 0) == 0) begin
                send_date($urandom_range(31, 0), $urandom_range(15, 0),
                          $urandom_range(16383, 0));
            end else begin
                send_date($urandom_range(31, 26), $urandom_range(12, 1),
                          ($urandom_range(3, 0) == 0) ? $urandom_range(9999, 9990)
                                                      : $urandom_range(9999, 0));
            end
        end else if (r < 33) begin
            send_bare(cclk_pkg::CMD_NONE);
        end else begin
            send_bare(cclk_pkg::CMD_TICK);
        end
    endtask

    initial begin : stimulus
        int unsigned tx_plan [PHASES];
        int unsigned rx_plan [PHASES];
        tx_plan = '{0, 14, 3, 0, 14, 7};
        rx_plan = '{0, 0, 14, 14, 3, 14};
        i_rst_n      = 1'b0;
        i_valid      = 1'b0;
        i_cmd        = cclk_pkg::CMD_NONE;
        i_new_hour   = '0;
        i_new_minute = '0;
        i_new_second = '0;
        i_new_day    = '0;
        i_new_month  = '0;
        i_new_year   = '0;
        repeat (6) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed: reset readout, all-ones and all-zeros payloads
        push_item(cclk_pkg::CMD_NONE, '1, '1, '1, '1, '1, '1);
        push_item(cclk_pkg::CMD_TICK, '0, '0, '0, '0, '0, '0);
        // last second of year 9999 wraps to year 0
        send_time(23, 59, 59);
        send_date(31, 12, 9999);
        send_bare(cclk_pkg::CMD_TICK);
        // end of February, common and leap year
        send_date(28, 2, 2023);
        send_time(23, 59, 59);
        send_bare(cclk_pkg::CMD_TICK);
        send_date(28, 2, 2024);
        send_time(23, 59, 59);
        send_bare(cclk_pkg::CMD_TICK);
        // 30-day month
        send_date(30, 4, 2022);
        send_time(23, 59, 59);
        send_bare(cclk_pkg::CMD_TICK);
        // time fields beyond range all carry on one tick
        send_time(31, 63, 63);
        send_bare(cclk_pkg::CMD_TICK);
        // day zero, month zero, year beyond range
        send_date(0, 0, 16383);
        send_bare(cclk_pkg::CMD_TICK);
        send_time(23, 59, 59);
        send_bare(cclk_pkg::CMD_TICK);
        // day 31 of month 15 rolls month and year together
        send_date(31, 15, 16383);
        send_time(23, 59, 59);
        send_bare(cclk_pkg::CMD_TICK);
        // lowest legal values
        send_time(0, 0, 0);
        send_date(1, 1, 0);
        send_bare(cclk_pkg::CMD_TICK);
        drain();

        // random phases with different idling on each side
        for (int p = 0; p < PHASES; p++) begin
            tx_idle_max = tx_plan[p];
            rx_idle_max = rx_plan[p];
            for (int n = 0; n < PHASE_ITEMS; n++) send_random_item();
            drain();
        end
        repeat (4) @(negedge i_clk);

        $display("%0d results checked over directed and random commands incl. unused code;",
                 checked);
        $display("%0d year rollovers, %0d wraps past 9999, %0d leap days reached by tick",
                 year_rolls, year_wraps, leap_days);
        if (fail_count == 0) begin
            $display("calendar_clock_counter_unit regression: pass");
        end else begin
            $display("calendar_clock_counter_unit regression: fail");
        end
        $finish;
    end

endmodule
